[hdl/ulcr_pkg.sv]
// ----------------------------------------------------------------------------
// ulcr_pkg
// Types and constants for the serial line command recognizer: byte codes,
// command texts, their lengths and the command code type.
// ----------------------------------------------------------------------------
package ulcr_pkg;

	typedef logic [6:0] char_t;
	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_RETURN = 2'd1,
		CMD_RESET  = 2'd2
	} cmd_code_t;

	localparam int unsigned CMD_COUNT  = 3;
	localparam int unsigned CMD_MAXLEN = 12;

	localparam byte_t CHAR_LF    = 8'h0A;
	localparam byte_t CHAR_CR    = 8'h0D;
	localparam byte_t CHAR_FIRST = 8'h20;
	localparam byte_t CHAR_LAST  = 8'h7E;

	// texts padded with NUL past their length
	localparam byte_t CMD_TEXT [CMD_COUNT][CMD_MAXLEN] = '{
		'{"B", "P", "A", "T", "H", " ", "S", "T", "A", "R", "T", 8'h00},
		'{"B", "P", "A", "T", "H", " ", "R", "E", "T", "U", "R", "N"},
		'{"B", "P", "A", "T", "H", " ", "R", "E", "S", "E", "T", 8'h00}
	};

	localparam int unsigned CMD_LEN [CMD_COUNT] = '{11, 12, 11};

endpackage

[hdl/uart_line_command_recognizer.sv]
// ----------------------------------------------------------------------------
// uart_line_command_recognizer
// Collects printable bytes into a line store and, on line feed, reports
// which of three fixed command texts the line equals.
// ----------------------------------------------------------------------------
// Order: an accepted line feed lands in the input register, and the result
// register loads from it once the output side can advance.
// Throughput: one byte per cycle; the input stalls only while a finished
// command waits in the result register and the input register is full.
// Reset: arst_n clears line length and all valid flags; stored chars are not reset.
module uart_line_command_recognizer
	import ulcr_pkg::*;
#(
	parameter int unsigned LINE_STORE = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output logic [1:0] command
);

	localparam int unsigned LINE_CAP = LINE_STORE - 1;
	localparam int unsigned LEN_W    = $clog2(LINE_STORE);
	localparam int unsigned IDX_W    = $clog2(LINE_CAP);

	logic             valid_s1;
	byte_t            byte_s1;
	logic             advance;
	logic             is_lf;
	logic             is_cr;
	logic             is_print;
	logic             has_room;
	logic [LEN_W-1:0] len_q;
	char_t            chars_q [LINE_CAP];
	logic [CMD_COUNT-1:0] hit;
	logic             found;
	cmd_code_t        code;
	logic             out_valid_q;
	cmd_code_t        out_cmd_q;

	assign advance  = !out_valid_q || cmd_ready;
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	assign is_lf    = (byte_s1 == CHAR_LF);
	assign is_cr    = (byte_s1 == CHAR_CR);
	assign is_print = (byte_s1 >= CHAR_FIRST) && (byte_s1 <= CHAR_LAST);
	assign has_room = (len_q < LEN_W'(LINE_CAP));

	always_comb begin
		for (int k = 0; k < CMD_COUNT; k++) begin
			hit[k] = (len_q == LEN_W'(CMD_LEN[k]));
			for (int i = 0; i < CMD_MAXLEN; i++) begin
				if (i < CMD_LEN[k] && i < LINE_CAP) begin
					if ({1'b0, chars_q[IDX_W'(i)]} != CMD_TEXT[k][i]) begin
						hit[k] = 1'b0;
					end
				end
			end
		end
	end

	always_comb begin
		found = 1'b1;
		code  = CMD_START;
		if (hit[0]) begin
			code = CMD_START;
		end else if (hit[1]) begin
			code = CMD_RETURN;
		end else if (hit[2]) begin
			code = CMD_RESET;
		end else begin
			found = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (valid_s1 && advance && !is_cr) begin
			if (is_print && has_room) begin
				len_q <= len_q + LEN_W'(1);
			end else begin
				len_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && is_print && has_room) begin
			chars_q[len_q[IDX_W-1:0]] <= byte_s1[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && is_lf && found;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && is_lf && found) begin
			out_cmd_q <= code;
		end
	end

	assign cmd_valid = out_valid_q;
	assign command   = out_cmd_q;

`ifndef SYNTH
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_CAP))
		else $error("line length past store capacity");

	a_lf_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && is_lf) |=> (len_q == '0))
		else $error("line feed did not clear line length");

	a_no_code3: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (command <= CMD_RESET))
		else $error("invalid command code on output");

	a_only_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !(valid_s1 && is_lf)) |=> !out_valid_q)
		else $error("result produced without a line feed");
`endif

endmodule

[test/tb_uart_line_command_recognizer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_line_command_recognizer
// Feeds byte streams of command lines, near misses, overlong lines, control
// bytes and noise. It predicts each recognized command from its own copy of
// the line store and matches every command result in order, with random
// gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_uart_line_command_recognizer;
	import ulcr_pkg::*;

	localparam int unsigned LINE_STORE = 24;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned RX_TARGET  = 1400;
	localparam int unsigned LONG_HOLD  = 300;

	class cmd_scoreboard;
		int unsigned line_cap;
		byte_t       line_chars[$];
		cmd_code_t   expected_cmds[$];
		string       cmd_text[3];
		cmd_code_t   cmd_code[3];
		int unsigned errors;

		function new(int unsigned cap);
			line_cap    = cap;
			errors      = 0;
			cmd_text[0] = "BPATH START";
			cmd_text[1] = "BPATH RETURN";
			cmd_text[2] = "BPATH RESET";
			cmd_code[0] = CMD_START;
			cmd_code[1] = CMD_RETURN;
			cmd_code[2] = CMD_RESET;
		endfunction

		function bit line_is(string s);
			if (s.len() != line_chars.size())
				return 1'b0;
			for (int i = 0; i < s.len(); i++) begin
				if (line_chars[i] != byte_t'(s[i]))
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_rx_byte(byte_t b);
			if (b == CHAR_CR)
				return;
			if (b == CHAR_LF) begin
				foreach (cmd_text[k]) begin
					if (line_is(cmd_text[k])) begin
						expected_cmds.push_back(cmd_code[k]);
						break;
					end
				end
				line_chars.delete();
				return;
			end
			if (b >= CHAR_FIRST && b <= CHAR_LAST && line_chars.size() < line_cap)
				line_chars.push_back(b);
			else
				line_chars.delete();
		endfunction

		function void check_command(logic [1:0] got);
			cmd_code_t want;
			if (expected_cmds.size() == 0) begin
				$error("command: expected none, got %0d", got);
				errors++;
				return;
			end
			want = expected_cmds.pop_front();
			if (got !== want) begin
				$error("command: expected %0d, got %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       rx_valid  = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte   = 8'h00;
	logic       cmd_valid;
	logic       cmd_ready = 1'b0;
	logic [1:0] command;

	cmd_scoreboard sb = new(LINE_STORE - 1);
	int unsigned   n_sent = 0;
	int unsigned   n_got  = 0;
	int unsigned   idle_cycles = 0;

	uart_line_command_recognizer #(
		.LINE_STORE(LINE_STORE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command  (command)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(byte_t b);
		int unsigned gap;
		gap = ((n_sent / 50) % 5 == 4) ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!rx_ready);
		sb.note_rx_byte(b);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string s, int cr_at);
		for (int i = 0; i < s.len(); i++) begin
			if (i == cr_at)
				send_byte(CHAR_CR);
			send_byte(byte_t'(s[i]));
		end
	endtask

	task automatic send_printables(int unsigned n);
		repeat (n) send_byte(byte_t'($urandom_range(CHAR_FIRST, CHAR_LAST)));
	endtask

	function automatic byte_t pick_junk();
		byte_t r;
		case ($urandom_range(0, 2))
			0: begin
				do r = byte_t'($urandom_range(0, 31));
				while (r == CHAR_CR || r == CHAR_LF);
			end
			1: r = 8'h7F;
			default: r = byte_t'($urandom_range(128, 255));
		endcase
		return r;
	endfunction

	task automatic send_random_request();
		int unsigned pick;
		int unsigned k;
		int unsigned pos;
		string       txt;
		pick = $urandom_range(0, 99);
		k    = $urandom_range(0, 2);
		txt  = sb.cmd_text[k];
		if (pick < 50) begin
			// clean command, sometimes with stray CRs
			send_text(txt, ($urandom_range(0, 3) == 0) ? $urandom_range(0, txt.len() - 1) : -1);
			if ($urandom_range(0, 1))
				send_byte(CHAR_CR);
			send_byte(CHAR_LF);
		end else if (pick < 65) begin
			// near miss
			case ($urandom_range(0, 3))
				0: begin
					pos = $urandom_range(0, txt.len() - 1);
					txt[pos] = byte'($urandom_range(CHAR_FIRST, CHAR_LAST));
					send_text(txt, -1);
				end
				1: send_text(txt.substr(0, txt.len() - 2), -1);
				2: begin
					send_text(txt, -1);
					send_printables(1);
				end
				default: begin
					send_printables(1);
					send_text(txt, -1);
				end
			endcase
			send_byte(CHAR_LF);
		end else if (pick < 77) begin
			// line from just under to past the store capacity
			send_printables(LINE_STORE - 2 + $urandom_range(0, 3));
			if ($urandom_range(0, 1))
				send_text(txt, -1);
			send_byte(CHAR_LF);
		end else if (pick < 89) begin
			// non-printable byte inside or ahead of a command
			pos = $urandom_range(0, txt.len() - 1);
			if ($urandom_range(0, 1)) begin
				send_text(txt.substr(0, pos), -1);
				send_byte(pick_junk());
				send_text(txt.substr(pos + 1, txt.len() - 1), -1);
			end else begin
				send_printables(pos);
				send_byte(pick_junk());
				send_text(txt, -1);
			end
			send_byte(CHAR_LF);
		end else begin
			repeat ($urandom_range(1, 8)) send_byte(byte_t'($urandom_range(0, 255)));
		end
	endtask

	// result side
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (n_got == 5 || n_got == 25)
				gap = LONG_HOLD;
			else
				gap = ((n_got / 8) % 4 == 3) ? 0 : $urandom_range(0, 3);
			if (gap != 0) begin
				cmd_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			cmd_ready <= 1'b1;
			do @(posedge clk); while (!cmd_valid);
			sb.check_command(command);
			n_got++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_valid && rx_ready) || (cmd_valid && cmd_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("FAIL uart_line_command_recognizer");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		send_text(sb.cmd_text[0], -1);
		send_byte(CHAR_LF);
		send_text(sb.cmd_text[1], -1);
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		send_text(sb.cmd_text[2], 5);
		send_byte(CHAR_LF);
		send_byte(CHAR_LF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'h1F);
		send_byte(CHAR_FIRST);
		send_byte(CHAR_LAST);
		send_byte(8'h80);
		send_byte(CHAR_LF);
		// full store: next printable is dropped and the line restarts
		send_printables(LINE_STORE - 1);
		send_byte("A");
		send_text(sb.cmd_text[0], -1);
		send_byte(CHAR_LF);
		send_text("BPATH STAR", -1);
		send_byte(CHAR_LF);
		send_printables(LINE_STORE - 1);
		send_byte(CHAR_LF);

		while (n_sent < RX_TARGET)
			send_random_request();
		rx_valid <= 1'b0;

		while (sb.expected_cmds.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS uart_line_command_recognizer");
		else
			$display("FAIL uart_line_command_recognizer");
		$finish;
	end

endmodule

[filelist.f]
hdl/ulcr_pkg.sv
hdl/uart_line_command_recognizer.sv
test/tb_uart_line_command_recognizer.sv
